// ===== src/gdn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gdn_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 22;

    // Pipeline depth: number of registered stages a request passes through
    localparam int PIPE_STAGES = 7;

    // Operation codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Calendar cycle lengths in days
    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;

    // Index of the last four-year group inside a century
    localparam int unsigned Q4_LAST = DAYS_100 / DAYS_4;

    // Last supported year and the serial of its final day
    localparam int unsigned MAX_YEAR   = 9999;
    localparam int unsigned MAX_SERIAL = MAX_YEAR * 365 + MAX_YEAR / 4
                                       - MAX_YEAR / 100 + MAX_YEAR / 400;

    // Reciprocals for constant division: q = (x * RECIP) >> SH
    localparam int RECIP_SH_400 = 40;
    localparam logic [22:0] RECIP_400 =
        23'(((64'd1 << RECIP_SH_400) + 64'(DAYS_400) - 64'd1) / 64'(DAYS_400));
    localparam int RECIP_SH_4 = 28;
    localparam logic [17:0] RECIP_4 =
        18'(((64'd1 << RECIP_SH_4) + 64'(DAYS_4) - 64'd1) / 64'(DAYS_4));
    localparam int RECIP_SH_25 = 20;
    localparam logic [15:0] RECIP_25 =
        16'(((64'd1 << RECIP_SH_25) + 64'd24) / 64'd25);

    // Length of a month in a common year; zero for codes that name no month
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m
    function automatic logic [8:0] f_days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Per-stage enables and valids from the flow control
    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe_ctl;

    // Request payload as it moves down the pipeline
    typedef struct packed {
        logic                func;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [SERIAL_W-1:0] serial;
        logic                clamp;
        logic                oor;
        // encode side
        logic [YEAR_W-1:0]   p;
        logic [11:0]         yq;
        logic [7:0]          cy;
        logic [11:0]         pq;
        logic [7:0]          cp;
        logic                leap;
        logic [22:0]         dby;
        logic [8:0]          off;
        // decode side
        logic [SERIAL_W-1:0] n;
        logic [4:0]          q400;
        logic [17:0]         r400;
        logic [1:0]          q100;
        logic [15:0]         r100;
        logic [4:0]          q4;
        logic [10:0]         r4;
        logic [1:0]          q1;
        logic [8:0]          doy;
        logic                dleap;
        // result
        logic [SERIAL_W-1:0] res_serial;
        logic [DAY_W-1:0]    res_day;
        logic [MONTH_W-1:0]  res_month;
        logic [YEAR_W-1:0]   res_year;
    } t_item;

endpackage

`default_nettype wire

// ===== src/gdn_pipe_ctl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gdn_pipe_ctl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_stall,
    output gdn_pkg::t_pipe_ctl      o_ctl
);

    logic [gdn_pkg::PIPE_STAGES-1:0] r_vld;
    logic [gdn_pkg::PIPE_STAGES-1:0] n_vld;
    logic [gdn_pkg::PIPE_STAGES-1:0] stage_en;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        stage_en[gdn_pkg::PIPE_STAGES-1] = !r_vld[gdn_pkg::PIPE_STAGES-1] || !i_stall;
        for (int k = gdn_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // Move valid bits along with the data
    always_comb begin
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < gdn_pkg::PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall   = !stage_en[0];
    assign o_ctl.en  = stage_en;
    assign o_ctl.vld = r_vld;

endmodule

`default_nettype wire

// ===== src/gregorian_day_number_converter.sv =====
// Converts between a proleptic Gregorian date and a serial day count with
// 0001-01-01 as day 1. A request with func 0 encodes day/month/year into a
// serial, clamping the day into the month (clamped flags it) and flagging a
// year of 0 or past 9999 through out_of_range with serial 0. A request with
// func 1 decodes a serial into day/month/year; serial 0 or anything past
// 9999-12-31 raises out_of_range and zeroes the date fields. The block is a
// seven-stage pipeline: it accepts one request every cycle while o_stall is low.
// The reciprocal multiplies for the 400-year and 4-year splits set the stage
// boundaries. Stalls back up through the stages without losing any request.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_day_number_converter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_func,
    input  wire logic [gdn_pkg::DAY_W-1:0]       i_day_in,
    input  wire logic [gdn_pkg::MONTH_W-1:0]     i_month_in,
    input  wire logic [gdn_pkg::YEAR_W-1:0]      i_year_in,
    input  wire logic [gdn_pkg::SERIAL_W-1:0]    i_serial_in,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [gdn_pkg::SERIAL_W-1:0]         o_serial_out,
    output logic [gdn_pkg::DAY_W-1:0]            o_day_out,
    output logic [gdn_pkg::MONTH_W-1:0]          o_month_out,
    output logic [gdn_pkg::YEAR_W-1:0]           o_year_out,
    output logic                                 o_clamped,
    output logic                                 o_out_of_range
);

    localparam int LAST = gdn_pkg::PIPE_STAGES - 1;

    gdn_pkg::t_pipe_ctl ctl;
    gdn_pkg::t_item     r_pipe [gdn_pkg::PIPE_STAGES];
    gdn_pkg::t_item     n_pipe [gdn_pkg::PIPE_STAGES];

    logic [gdn_pkg::YEAR_W-1:0]   w_p;
    logic [11:0]                  w_pq;
    logic [27:0]                  w_prod_y;
    logic [27:0]                  w_prod_p;
    logic [gdn_pkg::SERIAL_W-1:0] w_n;
    logic [44:0]                  w_prod_n;
    logic [11:0]                  w_r25;
    logic                         w_valid_month;
    logic [gdn_pkg::DAY_W-1:0]    w_mlen;
    logic [33:0]                  w_prod_4;
    logic [gdn_pkg::MONTH_W-1:0]  w_mon;
    logic [8:0]                   w_mstart;

    gdn_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    // Stage 0: capture request, start the divide-by-25 and 400-year reciprocal divisions, range checks
    always_comb begin
        n_pipe[0]        = '0;
        n_pipe[0].func   = i_func;
        n_pipe[0].day    = i_day_in;
        n_pipe[0].month  = i_month_in;
        n_pipe[0].year   = i_year_in;
        n_pipe[0].serial = i_serial_in;

        w_p      = i_year_in - gdn_pkg::YEAR_W'(1);
        w_pq     = w_p[gdn_pkg::YEAR_W-1:2];
        w_prod_y = 28'(i_year_in[gdn_pkg::YEAR_W-1:2]) * 28'(gdn_pkg::RECIP_25);
        w_prod_p = 28'(w_pq) * 28'(gdn_pkg::RECIP_25);
        n_pipe[0].p  = w_p;
        n_pipe[0].yq = i_year_in[gdn_pkg::YEAR_W-1:2];
        n_pipe[0].cy = w_prod_y[gdn_pkg::RECIP_SH_25 +: 8];
        n_pipe[0].pq = w_pq;
        n_pipe[0].cp = w_prod_p[gdn_pkg::RECIP_SH_25 +: 8];

        w_n      = i_serial_in - gdn_pkg::SERIAL_W'(1);
        w_prod_n = 45'(w_n) * 45'(gdn_pkg::RECIP_400);
        n_pipe[0].n    = w_n;
        n_pipe[0].q400 = w_prod_n[gdn_pkg::RECIP_SH_400 +: 5];

        if (i_func == gdn_pkg::FUNC_DECODE) begin
            n_pipe[0].oor = (i_serial_in == '0) || (32'(i_serial_in) > gdn_pkg::MAX_SERIAL);
        end else begin
            n_pipe[0].oor = (i_year_in == '0) || (32'(i_year_in) > gdn_pkg::MAX_YEAR);
        end
    end

    // Stage 1: leap test and year days on encode; 400-year remainder on decode
    always_comb begin
        n_pipe[1]      = r_pipe[0];
        w_r25          = 12'(r_pipe[0].yq - 12'(32'(r_pipe[0].cy) * 32'd25));
        n_pipe[1].leap = (r_pipe[0].year[1:0] == 2'b00)
                      && ((w_r25 != '0) || (r_pipe[0].cy[1:0] == 2'b00));
        n_pipe[1].dby  = 23'(r_pipe[0].p) * 23'(gdn_pkg::DAYS_1);
        n_pipe[1].r400 = 18'(r_pipe[0].n
                      - gdn_pkg::SERIAL_W'(32'(r_pipe[0].q400) * gdn_pkg::DAYS_400));
    end

    // Stage 2: finish days before year, clamp day, month offset; century split
    always_comb begin
        n_pipe[2]     = r_pipe[1];
        n_pipe[2].dby = r_pipe[1].dby + 23'(r_pipe[1].pq) - 23'(r_pipe[1].cp)
                      + 23'(r_pipe[1].cp[7:2]);

        w_valid_month = r_pipe[1].month inside {[gdn_pkg::MONTH_JAN:gdn_pkg::MONTH_DEC]};
        w_mlen = gdn_pkg::f_month_len(r_pipe[1].month)
               + gdn_pkg::DAY_W'((r_pipe[1].month == gdn_pkg::MONTH_FEB) && r_pipe[1].leap);
        if (r_pipe[1].func == gdn_pkg::FUNC_ENCODE) begin
            if (w_valid_month && (r_pipe[1].day > w_mlen)) begin
                n_pipe[2].day   = w_mlen;
                n_pipe[2].clamp = 1'b1;
            end
            if (r_pipe[1].day == '0) begin
                n_pipe[2].day   = gdn_pkg::DAY_W'(1);
                n_pipe[2].clamp = 1'b1;
            end
        end
        if (w_valid_month) begin
            n_pipe[2].off = gdn_pkg::f_days_before(r_pipe[1].month)
                          + 9'((r_pipe[1].month > gdn_pkg::MONTH_FEB) && r_pipe[1].leap);
        end else begin
            n_pipe[2].off = '0;
        end

        // Century count saturates at three so the last day of a 400-year cycle fits
        n_pipe[2].q100 = 2'(32'(r_pipe[1].r400 >= 18'(gdn_pkg::DAYS_100))
                       + 32'(r_pipe[1].r400 >= 18'(2 * gdn_pkg::DAYS_100))
                       + 32'(r_pipe[1].r400 >= 18'(3 * gdn_pkg::DAYS_100)));
        n_pipe[2].r100 = 16'(r_pipe[1].r400
                       - 18'(32'(n_pipe[2].q100) * gdn_pkg::DAYS_100));
    end

    // Stage 3: encode result; four-year quotient on decode
    always_comb begin
        n_pipe[3] = r_pipe[2];
        if (r_pipe[2].func == gdn_pkg::FUNC_ENCODE) begin
            n_pipe[3].res_serial = r_pipe[2].oor ? '0 :
                gdn_pkg::SERIAL_W'(r_pipe[2].dby + 23'(r_pipe[2].off) + 23'(r_pipe[2].day));
            n_pipe[3].res_day    = r_pipe[2].day;
            n_pipe[3].res_month  = r_pipe[2].month;
            n_pipe[3].res_year   = r_pipe[2].year;
        end
        w_prod_4     = 34'(r_pipe[2].r100) * 34'(gdn_pkg::RECIP_4);
        n_pipe[3].q4 = w_prod_4[gdn_pkg::RECIP_SH_4 +: 5];
    end

    // Stage 4: four-year remainder
    always_comb begin
        n_pipe[4]    = r_pipe[3];
        n_pipe[4].r4 = 11'(r_pipe[3].r100 - 16'(32'(r_pipe[3].q4) * gdn_pkg::DAYS_4));
    end

    // Stage 5: year within the group, day of year, decoded year and leap
    always_comb begin
        n_pipe[5]     = r_pipe[4];
        n_pipe[5].q1  = 2'(32'(r_pipe[4].r4 >= 11'(gdn_pkg::DAYS_1))
                      + 32'(r_pipe[4].r4 >= 11'(2 * gdn_pkg::DAYS_1))
                      + 32'(r_pipe[4].r4 >= 11'(3 * gdn_pkg::DAYS_1)));
        n_pipe[5].doy = 9'(r_pipe[4].r4 - 11'(32'(n_pipe[5].q1) * gdn_pkg::DAYS_1));
        n_pipe[5].dleap = (n_pipe[5].q1 == 2'd3)
                       && ((32'(r_pipe[4].q4) != gdn_pkg::Q4_LAST) || (r_pipe[4].q100 == 2'd3));
        if (r_pipe[4].func == gdn_pkg::FUNC_DECODE) begin
            n_pipe[5].res_year = gdn_pkg::YEAR_W'(32'(r_pipe[4].q400) * 32'd400
                               + 32'(r_pipe[4].q100) * 32'd100
                               + 32'(r_pipe[4].q4) * 32'd4
                               + 32'(n_pipe[5].q1) + 32'd1);
        end
    end

    // Stage 6: month search over the day of year, then day of month
    always_comb begin
        n_pipe[6] = r_pipe[5];
        w_mon     = gdn_pkg::MONTH_JAN;
        for (int k = 2; k <= 12; k++) begin
            if (r_pipe[5].doy >= gdn_pkg::f_days_before(gdn_pkg::MONTH_W'(k))
                    + 9'((k > 2) && r_pipe[5].dleap)) begin
                w_mon = w_mon + gdn_pkg::MONTH_W'(1);
            end
        end
        w_mstart = gdn_pkg::f_days_before(w_mon)
                 + 9'((w_mon > gdn_pkg::MONTH_FEB) && r_pipe[5].dleap);
        if (r_pipe[5].func == gdn_pkg::FUNC_DECODE) begin
            n_pipe[6].res_serial = r_pipe[5].serial;
            n_pipe[6].clamp      = 1'b0;
            if (r_pipe[5].oor) begin
                n_pipe[6].res_day   = '0;
                n_pipe[6].res_month = '0;
                n_pipe[6].res_year  = '0;
            end else begin
                n_pipe[6].res_day   = gdn_pkg::DAY_W'(r_pipe[5].doy - w_mstart + 9'd1);
                n_pipe[6].res_month = w_mon;
            end
        end
    end

    // Load each stage when its enable allows
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < gdn_pkg::PIPE_STAGES; k++) begin
            if (ctl.en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_valid        = ctl.vld[LAST];
    assign o_serial_out   = r_pipe[LAST].res_serial;
    assign o_day_out      = r_pipe[LAST].res_day;
    assign o_month_out    = r_pipe[LAST].res_month;
    assign o_year_out     = r_pipe[LAST].res_year;
    assign o_clamped      = r_pipe[LAST].clamp;
    assign o_out_of_range = r_pipe[LAST].oor;

endmodule

`default_nettype wire

// ===== verif/tb_gregorian_day_number_converter.sv =====
`timescale 1ns / 1ps

module tb_gregorian_day_number_converter;

    localparam int unsigned YEAR_LAST   = 9999;
    localparam int unsigned SERIAL_LAST = 3652059;
    localparam int unsigned CYCLE_400   = 146097;
    localparam int unsigned CYCLE_100   = 36524;
    localparam int unsigned CYCLE_4     = 1461;
    localparam int unsigned CYCLE_1     = 365;
    localparam int          RANDOM_REQS = 1700;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        logic                              func;
        logic [gdn_pkg::DAY_W-1:0]         day;
        logic [gdn_pkg::MONTH_W-1:0]       month;
        logic [gdn_pkg::YEAR_W-1:0]        year;
        logic [gdn_pkg::SERIAL_W-1:0]      serial;
    } t_date_req;

    typedef struct packed {
        logic [gdn_pkg::SERIAL_W-1:0]      serial;
        logic [gdn_pkg::DAY_W-1:0]         day;
        logic [gdn_pkg::MONTH_W-1:0]       month;
        logic [gdn_pkg::YEAR_W-1:0]        year;
        logic                              clamped;
        logic                              out_of_range;
    } t_date_res;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    t_date_req drv_req   = '0;
    logic      drv_valid = 1'b0;
    logic      rx_stall  = 1'b0;

    logic                         o_stall;
    logic                         o_valid;
    logic [gdn_pkg::SERIAL_W-1:0] o_serial_out;
    logic [gdn_pkg::DAY_W-1:0]    o_day_out;
    logic [gdn_pkg::MONTH_W-1:0]  o_month_out;
    logic [gdn_pkg::YEAR_W-1:0]   o_year_out;
    logic                         o_clamped;
    logic                         o_out_of_range;

    t_date_req pending_reqs[$];
    t_date_res expected_results[$];

    int fault_cnt    = 0;
    int accepted_cnt = 0;
    int cycle_cnt    = 0;
    int hold_cnt     = 0;
    int next_hold_at = 200;
    logic hold_active;

    gregorian_day_number_converter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (drv_valid),
        .o_stall        (o_stall),
        .i_func         (drv_req.func),
        .i_day_in       (drv_req.day),
        .i_month_in     (drv_req.month),
        .i_year_in      (drv_req.year),
        .i_serial_in    (drv_req.serial),
        .o_valid        (o_valid),
        .i_stall        (rx_stall),
        .o_serial_out   (o_serial_out),
        .o_day_out      (o_day_out),
        .o_month_out    (o_month_out),
        .o_year_out     (o_year_out),
        .o_clamped      (o_clamped),
        .o_out_of_range (o_out_of_range)
    );

    // Free-running clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input bit lp);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return lp ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Days of the year that come before the first of month m
    function automatic int unsigned days_before(input int unsigned m, input bit lp);
        int unsigned acc;
        acc = 0;
        for (int unsigned k = 1; k < m && k <= 12; k++)
            acc += month_days(k, 1'b0);
        if (m > 2 && lp)
            acc += 1;
        return acc;
    endfunction

    // Days in all years ahead of year y
    function automatic int unsigned year_start_offset(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    // Compute the result that the converter owes for one request
    function automatic t_date_res calendar_convert(input t_date_req rq);
        t_date_res   rs;
        int unsigned dd, len, n, rem, q400, q100, q4, q1, mm, yy;
        bit          lp, mvalid;
        rs = '0;
        if (rq.func == gdn_pkg::FUNC_ENCODE) begin
            lp     = leap_year(rq.year);
            mvalid = (rq.month >= 1) && (rq.month <= 12);
            dd     = rq.day;
            if (mvalid) begin
                len = month_days(rq.month, lp);
                if (dd > len) begin
                    dd = len;
                    rs.clamped = 1'b1;
                end
            end
            if (dd < 1) begin
                dd = 1;
                rs.clamped = 1'b1;
            end
            if (rq.year == 0 || rq.year > YEAR_LAST) begin
                rs.out_of_range = 1'b1;
            end else begin
                rs.serial = gdn_pkg::SERIAL_W'(year_start_offset(rq.year)
                            + (mvalid ? days_before(rq.month, lp) : 0) + dd);
            end
            rs.day   = gdn_pkg::DAY_W'(dd);
            rs.month = rq.month;
            rs.year  = rq.year;
        end else begin
            rs.serial = rq.serial;
            if (rq.serial == 0 || rq.serial > SERIAL_LAST) begin
                rs.out_of_range = 1'b1;
            end else begin
                n    = rq.serial - 1;
                q400 = n / CYCLE_400;
                rem  = n % CYCLE_400;
                q100 = rem / CYCLE_100;
                if (q100 > 3)
                    q100 = 3;
                rem -= q100 * CYCLE_100;
                q4   = rem / CYCLE_4;
                rem  = rem % CYCLE_4;
                q1   = rem / CYCLE_1;
                if (q1 > 3)
                    q1 = 3;
                rem -= q1 * CYCLE_1;
                yy = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
                lp = leap_year(yy);
                mm = 1;
                while (mm < 12 && rem >= days_before(mm + 1, lp))
                    mm++;
                rs.day   = gdn_pkg::DAY_W'(rem - days_before(mm, lp) + 1);
                rs.month = gdn_pkg::MONTH_W'(mm);
                rs.year  = gdn_pkg::YEAR_W'(yy);
            end
        end
        return rs;
    endfunction

    // Queue an encode request; the serial field carries noise
    task automatic queue_encode(input int unsigned d, input int unsigned m,
                                input int unsigned y);
        t_date_req rq;
        rq.func   = gdn_pkg::FUNC_ENCODE;
        rq.day    = gdn_pkg::DAY_W'(d);
        rq.month  = gdn_pkg::MONTH_W'(m);
        rq.year   = gdn_pkg::YEAR_W'(y);
        rq.serial = gdn_pkg::SERIAL_W'($urandom);
        pending_reqs.push_back(rq);
    endtask

    // Queue a decode request; the date fields carry noise
    task automatic queue_decode(input int unsigned s);
        t_date_req rq;
        rq.func   = gdn_pkg::FUNC_DECODE;
        rq.day    = gdn_pkg::DAY_W'($urandom);
        rq.month  = gdn_pkg::MONTH_W'($urandom);
        rq.year   = gdn_pkg::YEAR_W'($urandom);
        rq.serial = gdn_pkg::SERIAL_W'(s);
        pending_reqs.push_back(rq);
    endtask

    function automatic int unsigned serial_of(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
        t_date_req rq;
        t_date_res rs;
        rq        = '0;
        rq.func   = gdn_pkg::FUNC_ENCODE;
        rq.day    = gdn_pkg::DAY_W'(d);
        rq.month  = gdn_pkg::MONTH_W'(m);
        rq.year   = gdn_pkg::YEAR_W'(y);
        rs        = calendar_convert(rq);
        return rs.serial;
    endfunction

    // Pick a year, with century and quad-century years drawn often
    function automatic int unsigned pick_year();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(1, 99) * 100;
            1:       return $urandom_range(1, 24) * 400;
            2:       return $urandom_range(1, 40);
            default: return $urandom_range(1, YEAR_LAST);
        endcase
    endfunction

    // Offer requests in bursts with random gaps; hold payload while stalled
    always @(posedge i_clk) begin : drive_proc
        int        burst_left;
        int        gap_left;
        t_date_req nxt;
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!drv_valid || !o_stall) begin
            if (gap_left > 0 && !hold_active) begin
                drv_valid <= 1'b0;
                gap_left  = gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                nxt       = pending_reqs.pop_front();
                drv_req   <= nxt;
                drv_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Count out the long receiver hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (accepted_cnt >= next_hold_at) begin
            hold_cnt     <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 900;
        end
    end

    assign hold_active = (hold_cnt != 0);

    // Stall the output on a pattern that changes mode every segment
    always @(posedge i_clk) begin : stall_proc
        t_stall_mode mode;
        int          seg_left;
        int          phase;
        bit          pat;
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
            mode     = STALL_NONE;
            seg_left = 0;
            phase    = 0;
        end else begin
            if (seg_left == 0) begin
                mode     = t_stall_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(16, 160);
            end else begin
                seg_left = seg_left - 1;
            end
            phase = phase + 1;
            case (mode)
                STALL_LIGHT:    pat = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    pat = ($urandom_range(0, 9) < 6);
                STALL_PERIODIC: pat = ((phase % 3) == 0);
                default:        pat = 1'b0;
            endcase
            rx_stall <= hold_active || pat;
        end
    end

    // Record accepted requests and check each result against the oldest one
    always @(posedge i_clk) begin : check_proc
        t_date_res want;
        t_date_res got;
        if (i_rst_n) begin
            if (drv_valid && !o_stall) begin
                expected_results.push_back(calendar_convert(drv_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (o_valid && !rx_stall) begin
                got.serial       = o_serial_out;
                got.day          = o_day_out;
                got.month        = o_month_out;
                got.year         = o_year_out;
                got.clamped      = o_clamped;
                got.out_of_range = o_out_of_range;
                if (expected_results.size() == 0) begin
                    if (fault_cnt < REPORT_MAX)
                        $display("unexpected result: serial=%0d %0d-%0d-%0d clamp=%0b oor=%0b",
                                 got.serial, got.year, got.month, got.day,
                                 got.clamped, got.out_of_range);
                    fault_cnt = fault_cnt + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.serial !== want.serial || got.day !== want.day
                        || got.month !== want.month || got.year !== want.year
                        || got.clamped !== want.clamped
                        || got.out_of_range !== want.out_of_range) begin
                        if (fault_cnt < REPORT_MAX)
                            $display({"mismatch: exp serial=%0d %0d-%0d-%0d clamp=%0b oor=%0b",
                                      " got serial=%0d %0d-%0d-%0d clamp=%0b oor=%0b"},
                                     want.serial, want.year, want.month, want.day,
                                     want.clamped, want.out_of_range,
                                     got.serial, got.year, got.month, got.day,
                                     got.clamped, got.out_of_range);
                        fault_cnt = fault_cnt + 1;
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stim_proc
        int unsigned y, m, d, sel;

        // Directed encodes: field extremes and every clamp case
        queue_encode(1, 1, 1);
        queue_encode(31, 12, YEAR_LAST);
        queue_encode(0, 1, 2000);
        queue_encode(31, 2, 2000);
        queue_encode(29, 2, 1900);
        queue_encode(29, 2, 2024);
        queue_encode(31, 4, 2023);
        queue_encode(31, 0, 500);
        queue_encode(0, 13, 77);
        queue_encode(31, 15, 16383);
        queue_encode(15, 6, 0);
        queue_encode(1, 1, YEAR_LAST + 1);
        queue_encode(0, 0, 0);

        // Directed decodes: range edges, leap days and year ends
        queue_decode(0);
        queue_decode(1);
        queue_decode(SERIAL_LAST);
        queue_decode(SERIAL_LAST + 1);
        queue_decode(4194303);
        queue_decode(serial_of(29, 2, 2000));
        queue_decode(serial_of(1, 3, 1900));
        queue_decode(serial_of(31, 12, 400));
        queue_decode(serial_of(31, 12, 100));
        queue_decode(serial_of(31, 12, 4));
        queue_decode(serial_of(1, 1, 2001));

        // Random mix, weighted toward well-formed dates and in-range serials
        for (int i = 0; i < RANDOM_REQS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                y = pick_year();
                m = $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    0, 1, 2: d = $urandom_range(28, 31);
                    3:       d = 0;
                    default: d = $urandom_range(1, 31);
                endcase
                queue_encode(d, m, y);
            end else if (sel < 50) begin
                queue_encode($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 16383));
            end else if (sel < 80) begin
                queue_decode($urandom_range(1, SERIAL_LAST));
            end else if (sel < 92) begin
                y = pick_year();
                case ($urandom_range(0, 5))
                    0: queue_decode(serial_of(31, 12, y));
                    1: queue_decode(serial_of(1, 1, y));
                    2: queue_decode(serial_of(28, 2, y));
                    3: queue_decode(serial_of(29, 2, y));
                    4: queue_decode(serial_of(1, 3, y));
                    default: queue_decode(serial_of(31, $urandom_range(1, 12), y));
                endcase
            end else begin
                queue_decode($urandom_range(0, 4194303));
            end
        end

        // Release reset
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait until the last request is on the bus, then until it and
        // every result have gone through
        @(posedge i_clk);
        while (pending_reqs.size() > 0)
            @(posedge i_clk);
        @(posedge i_clk);
        while (drv_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_cnt == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
